[src/psos_pkg.sv]
// Shared types and constants for the popcount search-order sequencer.
`timescale 1ns / 1ps
`default_nettype none

package psos_pkg;

  // Popcount bins, counters and bound fields
  localparam int unsigned PopW = 11;
  // Threshold is Q0.16 with one extra bit so that 1.0 is representable
  localparam int unsigned FracW = 16;
  localparam int unsigned ThrW = FracW + 1;
  // Product width of a threshold and a popcount
  localparam int unsigned ProdW = ThrW + PopW;
  // Default fingerprint bit count and index width
  localparam int unsigned MaxBits = 1024;
  localparam int unsigned IndexBits = 24;

  // Configuration port
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = ThrW;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxPopcount = 1'b1;

  // Reset value of the largest bin, the bit count kept to the bin width
  localparam logic [PopW-1:0] MaxPopReset = PopW'(MaxBits);

  typedef enum logic [1:0] {
    ModeStart = 2'd0,
    ModeNext  = 2'd1,
    ModeCheck = 2'd2,
    ModeNop   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    DirBoth = 2'd0,
    DirUp   = 2'd1,
    DirDown = 2'd2,
    DirDone = 2'd3
  } dir_e;

endpackage

`default_nettype wire

[src/popcount_search_order_sequencer.sv]
// Top level: Tanimoto popcount-bin search-order sequencer with range clamping.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+---------------------------------------
// in        | input     | in_valid_i/in_stall_o   | mode, query popcount, range, window
// out       | output    | out_valid_o/out_stall_i | step_ok, bin, bound, clamped range
// cfg       | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled; each item passes the input
// register, then the result register. The four products (q*q against down*up, and the two
// threshold cross-products) are formed side by side in the one stage.
// Reset clears the direction to finished, the counters to zero, the
// threshold to zero and the largest bin to the fingerprint bit count.
// A stalled result holds the result register; the input register keeps
// taking transfers until it too is full.
module popcount_search_order_sequencer #(
  parameter int unsigned INDEX_BITS = psos_pkg::IndexBits
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration
  input  wire                            cfg_we_i,
  input  wire [psos_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire [psos_pkg::CfgDataW-1:0]   cfg_data_i,
  // input channel
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire [1:0]                      mode_i,
  input  wire [psos_pkg::PopW-1:0]       qry_pop_i,
  input  wire [INDEX_BITS-1:0]           range_start_i,
  input  wire [INDEX_BITS-1:0]           range_end_i,
  input  wire [INDEX_BITS-1:0]           window_start_i,
  input  wire [INDEX_BITS-1:0]           window_end_i,
  // output channel
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic                           step_ok_o,
  output logic [psos_pkg::PopW-1:0]      bin_popcount_o,
  output logic [psos_pkg::PopW-1:0]      bound_num_o,
  output logic [psos_pkg::PopW-1:0]      bound_den_o,
  output logic [INDEX_BITS-1:0]          clamped_start_o,
  output logic [INDEX_BITS-1:0]          clamped_end_o,
  output logic                           finished_o
);

  localparam int unsigned PopW  = psos_pkg::PopW;
  localparam int unsigned ThrW  = psos_pkg::ThrW;
  localparam int unsigned ProdW = psos_pkg::ProdW;
  localparam int unsigned FracW = psos_pkg::FracW;

  // Close the upward direction
  function automatic psos_pkg::dir_e close_up(input psos_pkg::dir_e dir);
    psos_pkg::dir_e res;
    res = dir;
    if (dir == psos_pkg::DirBoth) res = psos_pkg::DirDown;
    else if (dir == psos_pkg::DirUp) res = psos_pkg::DirDone;
    return res;
  endfunction

  // Close the downward direction
  function automatic psos_pkg::dir_e close_down(input psos_pkg::dir_e dir);
    psos_pkg::dir_e res;
    res = dir;
    if (dir == psos_pkg::DirBoth) res = psos_pkg::DirUp;
    else if (dir == psos_pkg::DirDown) res = psos_pkg::DirDone;
    return res;
  endfunction

  // Configuration registers
  logic [ThrW-1:0] thr_q;
  logic [PopW-1:0] max_pop_q;

  // Search state
  psos_pkg::dir_e  dir_q, dir_d;
  logic [PopW-1:0] query_q, query_d;
  logic [PopW-1:0] up_q, up_d;
  logic [PopW:0]   down_q, down_d;   // two's complement, reaches -1

  // Input register
  logic                  in_valid_q;
  psos_pkg::mode_e       mode_q;
  logic [PopW-1:0]       qpop_q;
  logic [INDEX_BITS-1:0] rs_q, re_q, ws_q, we_q;

  // Result register
  logic                  out_valid_q;
  logic                  ok_q, ok_d;
  logic [PopW-1:0]       bin_q, bin_d;
  logic [PopW-1:0]       num_q, num_d;
  logic [PopW-1:0]       den_q, den_d;
  logic [INDEX_BITS-1:0] cs_q, cs_d;
  logic [INDEX_BITS-1:0] ce_q, ce_d;
  logic                  fin_q;

  // Handshake
  logic advance;
  logic in_take;

  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_stall_o = in_valid_q && !advance;

  // Pending downward bin, never below zero
  logic [PopW-1:0] down_bin;
  assign down_bin = down_q[PopW] ? '0 : down_q[PopW-1:0];

  // Ordering products: q*q against down*up
  logic [2*PopW-1:0] qq_prod, du_prod;
  assign qq_prod = {{PopW{1'b0}}, query_q} * {{PopW{1'b0}}, query_q};
  assign du_prod = {{PopW{1'b0}}, down_bin} * {{PopW{1'b0}}, up_q};

  // Threshold cross-products for both candidate bounds
  logic [ProdW-1:0] up_thr_prod, dn_thr_prod;
  logic [ProdW-1:0] up_scaled, dn_scaled;
  logic             up_below, dn_below;

  assign up_thr_prod = {{PopW{1'b0}}, thr_q} * {{ThrW{1'b0}}, up_q};
  assign dn_thr_prod = {{PopW{1'b0}}, thr_q} * {{ThrW{1'b0}}, query_q};
  assign up_scaled   = {1'b0, query_q, {FracW{1'b0}}};
  assign dn_scaled   = {1'b0, down_bin, {FracW{1'b0}}};
  // A zero denominator always passes
  assign up_below    = (up_q != '0) && (up_scaled < up_thr_prod);
  assign dn_below    = (query_q != '0) && (dn_scaled < dn_thr_prod);

  // Work out one item and the next state
  logic           take_up;
  psos_pkg::dir_e dir_step;
  psos_pkg::dir_e dir_lo;

  always_comb begin
    dir_d    = dir_q;
    query_d  = query_q;
    up_d     = up_q;
    down_d   = down_q;
    ok_d     = 1'b0;
    bin_d    = '0;
    num_d    = '0;
    den_d    = '0;
    cs_d     = '0;
    ce_d     = '0;
    take_up  = 1'b0;
    dir_step = dir_q;
    dir_lo   = dir_q;
    unique case (mode_q)
      psos_pkg::ModeStart: begin
        query_d = qpop_q;
        up_d    = qpop_q;
        if (qpop_q <= PopW'(1)) begin
          dir_d  = psos_pkg::DirUp;
          down_d = '0;
        end else begin
          dir_d  = psos_pkg::DirBoth;
          down_d = {1'b0, qpop_q} - (PopW+1)'(1);
        end
        ok_d  = 1'b1;
        bin_d = qpop_q;
      end
      psos_pkg::ModeNext: begin
        if (dir_q != psos_pkg::DirDone) begin
          if (dir_q == psos_pkg::DirBoth) take_up = (up_q == '0) || (qq_prod >= du_prod);
          else take_up = (dir_q == psos_pkg::DirUp);
          if (take_up) begin
            bin_d = up_q;
            num_d = query_q;
            den_d = up_q;
            up_d  = up_q + PopW'(1);
            if (up_q >= max_pop_q) dir_step = close_up(dir_q);
          end else begin
            bin_d  = down_bin;
            num_d  = down_bin;
            den_d  = query_q;
            down_d = {1'b0, down_bin} - (PopW+1)'(1);
            // stepping past bin zero ends the downward run
            if (down_bin == '0) dir_step = close_down(dir_q);
          end
          if (take_up ? up_below : dn_below) begin
            dir_d = psos_pkg::DirDone;
          end else begin
            dir_d = dir_step;
            ok_d  = 1'b1;
          end
        end
      end
      psos_pkg::ModeCheck: begin
        if (rs_q > we_q) begin
          dir_d = close_up(dir_q);
        end else if (re_q < ws_q) begin
          dir_d = close_down(dir_q);
        end else begin
          // clamp each end to the window and close that side
          cs_d = rs_q;
          ce_d = re_q;
          if (rs_q < ws_q) begin
            dir_lo = close_up(dir_q);
            cs_d   = ws_q;
          end
          dir_d = dir_lo;
          if (re_q > we_q) begin
            dir_d = close_down(dir_lo);
            ce_d  = we_q;
          end
          ok_d = 1'b1;
        end
      end
      psos_pkg::ModeNop: begin
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= '0;
      max_pop_q <= psos_pkg::MaxPopReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == psos_pkg::CfgThreshold) thr_q <= cfg_data_i[ThrW-1:0];
      if (cfg_index_i == psos_pkg::CfgMaxPopcount) max_pop_q <= cfg_data_i[PopW-1:0];
    end
  end

  // Search state: advance with each item leaving the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= psos_pkg::DirDone;
      query_q <= '0;
      up_q    <= '0;
      down_q  <= '0;
    end else if (advance) begin
      dir_q   <= dir_d;
      query_q <= query_d;
      up_q    <= up_d;
      down_q  <= down_d;
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q <= psos_pkg::mode_e'(mode_i);
      qpop_q <= qry_pop_i;
      rs_q   <= range_start_i;
      re_q   <= range_end_i;
      ws_q   <= window_start_i;
      we_q   <= window_end_i;
    end
  end

  // Result register valid: hold while stalled, drop once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ok_q  <= ok_d;
      bin_q <= bin_d;
      num_q <= num_d;
      den_q <= den_d;
      cs_q  <= cs_d;
      ce_q  <= ce_d;
      fin_q <= (dir_d == psos_pkg::DirDone);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign step_ok_o       = ok_q;
  assign bin_popcount_o  = bin_q;
  assign bound_num_o     = num_q;
  assign bound_den_o     = den_q;
  assign clamped_start_o = cs_q;
  assign clamped_end_o   = ce_q;
  assign finished_o      = fin_q;

endmodule

`default_nettype wire

[verif/popcount_search_order_sequencer_tb.sv]
// Self-checking testbench for the popcount search-order sequencer.
`timescale 1ns / 1ps

module popcount_search_order_sequencer_tb;
  import psos_pkg::*;

  localparam logic [IndexBits-1:0] IdxMax = {IndexBits{1'b1}};
  localparam int NumPhases = 8;
  localparam int ItemsPerPhase = 188;
  localparam int DrainLimit = 2000;
  localparam int ReportLimit = 10;

  typedef struct packed {
    mode_e                mode;
    logic [PopW-1:0]      query;
    logic [IndexBits-1:0] rng_start;
    logic [IndexBits-1:0] rng_end;
    logic [IndexBits-1:0] win_start;
    logic [IndexBits-1:0] win_end;
  } request_t;

  typedef struct packed {
    logic                 ok;
    logic [PopW-1:0]      bin;
    logic [PopW-1:0]      num;
    logic [PopW-1:0]      den;
    logic [IndexBits-1:0] lo;
    logic [IndexBits-1:0] hi;
    logic                 fin;
  } answer_t;

  typedef struct {
    request_t req;
    bit       typed;
    answer_t  want;
  } vector_t;

  // Block ports
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = CfgThreshold;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           mode = ModeNop;
  logic [PopW-1:0]      qry_pop = '0;
  logic [IndexBits-1:0] range_start = '0;
  logic [IndexBits-1:0] range_end = '0;
  logic [IndexBits-1:0] window_start = '0;
  logic [IndexBits-1:0] window_end = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 step_ok;
  logic [PopW-1:0]      bin_popcount;
  logic [PopW-1:0]      bound_num;
  logic [PopW-1:0]      bound_den;
  logic [IndexBits-1:0] clamped_start;
  logic [IndexBits-1:0] clamped_end;
  logic                 finished;

  // Predicted block state and register copies
  logic [ThrW-1:0]      thr_reg = '0;
  logic [PopW-1:0]      max_pop_reg = MaxPopReset;
  dir_e                 srch_dir = DirDone;
  logic [PopW-1:0]      srch_query = '0;
  logic [PopW-1:0]      srch_up = '0;
  logic signed [PopW:0] srch_down = '0;

  answer_t pending_results[$];
  vector_t directed[$];
  answer_t seen_answer;
  answer_t due_answer;
  int      mismatch_count = 0;
  bit      tx_calm = 1'b0;
  bit      rx_calm = 1'b0;

  popcount_search_order_sequencer u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .mode_i          (mode),
    .qry_pop_i       (qry_pop),
    .range_start_i   (range_start),
    .range_end_i     (range_end),
    .window_start_i  (window_start),
    .window_end_i    (window_end),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .step_ok_o       (step_ok),
    .bin_popcount_o  (bin_popcount),
    .bound_num_o     (bound_num),
    .bound_den_o     (bound_den),
    .clamped_start_o (clamped_start),
    .clamped_end_o   (clamped_end),
    .finished_o      (finished)
  );

  initial forever #2 clk = ~clk;

  // Give up on a hung run
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void close_upward();
    if (srch_dir == DirBoth) srch_dir = DirDown;
    else if (srch_dir == DirUp) srch_dir = DirDone;
  endfunction

  function automatic void close_downward();
    if (srch_dir == DirBoth) srch_dir = DirUp;
    else if (srch_dir == DirDown) srch_dir = DirDone;
  endfunction

  // Advance the predicted search state by one transfer and return its result
  function automatic answer_t advance_search(input request_t req);
    answer_t              ans;
    longint unsigned      lhs;
    longint unsigned      rhs;
    logic [PopW-1:0]      dn;
    logic                 take_up;
    logic [IndexBits-1:0] lo;
    logic [IndexBits-1:0] hi;
    ans = '0;
    case (req.mode)
      ModeStart: begin
        srch_query = req.query;
        srch_up = req.query;
        if (req.query <= 1) begin
          srch_dir = DirUp;
          srch_down = '0;
        end else begin
          srch_dir = DirBoth;
          srch_down = $signed({1'b0, req.query}) - (PopW+1)'(1);
        end
        ans.ok = 1'b1;
        ans.bin = req.query;
      end
      ModeNext: begin
        if (srch_dir != DirDone) begin
          dn = srch_down[PopW] ? '0 : srch_down[PopW-1:0];
          // Pick the direction with the better bound: q/up against down/q
          if (srch_dir == DirBoth) begin
            lhs = 64'(srch_query);
            lhs = lhs * 64'(srch_query);
            rhs = 64'(dn);
            rhs = rhs * 64'(srch_up);
            take_up = (srch_up == '0) || (lhs >= rhs);
          end else begin
            take_up = (srch_dir == DirUp);
          end
          if (take_up) begin
            ans.bin = srch_up;
            ans.num = srch_query;
            ans.den = srch_up;
            srch_up = srch_up + 1'b1;
            if (ans.bin >= max_pop_reg) close_upward();
          end else begin
            ans.bin = dn;
            ans.num = dn;
            ans.den = srch_query;
            srch_down = $signed({1'b0, dn}) - (PopW+1)'(1);
            if (srch_down < 0) close_downward();
          end
          // Exact Q1.16 comparison; a zero denominator always passes
          lhs = 64'(ans.num);
          lhs = lhs << FracW;
          rhs = 64'(thr_reg);
          rhs = rhs * 64'(ans.den);
          if (ans.den != '0 && lhs < rhs) begin
            srch_dir = DirDone;
            ans.ok = 1'b0;
          end else begin
            ans.ok = 1'b1;
          end
        end
      end
      ModeCheck: begin
        lo = req.rng_start;
        hi = req.rng_end;
        if (lo > req.win_end) begin
          close_upward();
        end else if (hi < req.win_start) begin
          close_downward();
        end else begin
          if (lo < req.win_start) begin
            close_upward();
            lo = req.win_start;
          end
          if (hi > req.win_end) begin
            close_downward();
            hi = req.win_end;
          end
          ans.ok = 1'b1;
          ans.lo = lo;
          ans.hi = hi;
        end
      end
      default: ;
    endcase
    ans.fin = (srch_dir == DirDone);
    return ans;
  endfunction

  function automatic string describe(input answer_t a);
    return $sformatf("ok=%0d bin=%0d num=%0d den=%0d start=%h end=%h fin=%0d",
                     a.ok, a.bin, a.num, a.den, a.lo, a.hi, a.fin);
  endfunction

  function automatic int pick_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic [IndexBits-1:0] index_between(input logic [IndexBits-1:0] lo,
                                                         input logic [IndexBits-1:0] hi);
    return IndexBits'($urandom_range(lo, hi));
  endfunction

  // Mostly short searches, with the edges of the popcount range now and then
  function automatic logic [PopW-1:0] random_query();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return '0;
    if (pick < 8) return PopW'(1);
    if (pick < 11) return PopW'(MaxBits);
    if (pick < 14) return max_pop_reg;
    if (pick < 17) return (max_pop_reg < MaxBits) ? max_pop_reg + 1'b1 : PopW'(MaxBits);
    if (pick < 65) return PopW'($urandom_range(0, 48));
    return PopW'($urandom_range(0, MaxBits));
  endfunction

  // Mostly start-then-next runs with checks mixed in; the rest is noise
  function automatic request_t draw_request();
    request_t             req;
    int                   pick;
    logic [IndexBits-1:0] v0;
    logic [IndexBits-1:0] v1;
    logic [IndexBits-1:0] v2;
    logic [IndexBits-1:0] v3;
    req.mode = mode_e'(2'($urandom_range(0, 3)));
    req.query = random_query();
    req.rng_start = index_between('0, IdxMax);
    req.rng_end = index_between('0, IdxMax);
    req.win_start = index_between('0, IdxMax);
    req.win_end = index_between('0, IdxMax);
    pick = $urandom_range(0, 99);
    if (srch_dir == DirDone ? pick < 50 : pick < 5) begin
      req.mode = ModeStart;
    end else if (pick < 82) begin
      req.mode = ModeNext;
    end else if (pick < 95) begin
      req.mode = ModeCheck;
      // Ordered corners v0 <= v1 <= v2 <= v3, drawn from either end
      if ($urandom_range(0, 1) == 0) begin
        v0 = index_between('0, IdxMax);
        v1 = index_between(v0, IdxMax);
        v2 = index_between(v1, IdxMax);
        v3 = index_between(v2, IdxMax);
      end else begin
        v3 = index_between('0, IdxMax);
        v2 = index_between('0, v3);
        v1 = index_between('0, v2);
        v0 = index_between('0, v1);
      end
      case ($urandom_range(0, 6))
        0: {req.win_start, req.rng_start, req.rng_end, req.win_end} = {v0, v1, v2, v3};
        1: {req.rng_start, req.win_start, req.rng_end, req.win_end} = {v0, v1, v2, v3};
        2: {req.win_start, req.rng_start, req.win_end, req.rng_end} = {v0, v1, v2, v3};
        3: {req.rng_start, req.win_start, req.win_end, req.rng_end} = {v0, v1, v2, v3};
        4: {req.win_start, req.win_end, req.rng_start, req.rng_end} = {v0, v1, v2, v3};
        5: {req.rng_start, req.rng_end, req.win_start, req.win_end} = {v0, v1, v2, v3};
        default: ;
      endcase
    end
    return req;
  endfunction

  function automatic void add_vector(input mode_e m, input logic [PopW-1:0] q,
                                     input logic [IndexBits-1:0] rs,
                                     input logic [IndexBits-1:0] re,
                                     input logic [IndexBits-1:0] ws,
                                     input logic [IndexBits-1:0] we,
                                     input bit typed, input answer_t want);
    vector_t v;
    v.req = '{mode: m, query: q, rng_start: rs, rng_end: re, win_start: ws, win_end: we};
    v.typed = typed;
    v.want = want;
    directed.push_back(v);
  endfunction

  // Hold off, present one transfer and record its expected result once taken
  task automatic send_item(input request_t req, input bit typed, input answer_t want);
    int      gap;
    answer_t predicted;
    if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
    gap = pick_wait(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= req.mode;
    qry_pop <= req.query;
    range_start <= req.rng_start;
    range_end <= req.rng_end;
    window_start <= req.win_start;
    window_end <= req.win_end;
    do @(posedge clk); while (in_stall);
    predicted = advance_search(req);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and let every outstanding result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    for (int k = 0; k < DrainLimit && pending_results.size() != 0; k++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_registers(input logic [ThrW-1:0] thr, input logic [PopW-1:0] max_pop);
    cfg_we <= 1'b1;
    cfg_index <= CfgThreshold;
    cfg_data <= CfgDataW'(thr);
    @(posedge clk);
    thr_reg = thr;
    cfg_index <= CfgMaxPopcount;
    cfg_data <= CfgDataW'(max_pop);
    @(posedge clk);
    max_pop_reg = max_pop;
    cfg_we <= 1'b0;
  endtask

  // Result sink: stall for a drawn number of cycles ahead of each transfer
  initial begin : result_sink
    int hold;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      hold = pick_wait(rx_calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_answer = {step_ok, bin_popcount, bound_num, bound_den,
                     clamped_start, clamped_end, finished};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("%0t: result with none expected: %s", $time, describe(seen_answer));
      end else begin
        due_answer = pending_results.pop_front();
        if (seen_answer !== due_answer) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("%0t: expected %s", $time, describe(due_answer));
            $display("%0t: actual   %s", $time, describe(seen_answer));
          end
        end
      end
    end
  end

  initial begin : stimulus
    int              counted;
    logic [ThrW-1:0] thr_plan[NumPhases];
    logic [PopW-1:0] pop_plan[NumPhases];
    request_t        req;
    thr_plan = '{17'd0, 17'd65536, 17'd0, 17'd65536, 17'd52429, 17'd39322, 17'd0, 17'd0};
    pop_plan = '{11'd1024, 11'd1024, 11'd0, 11'd0, 11'd1024, 11'd100, 11'd0, 11'd0};

    // Walk the edges first: idle block, zero and full queries, clamping corners
    add_vector(ModeNext, '0, '0, '0, '0, '0, 1'b1, {1'b0, 33'd0, 48'd0, 1'b1});
    add_vector(ModeNop, 11'h7FF, IdxMax, IdxMax, IdxMax, IdxMax, 1'b1,
               {1'b0, 33'd0, 48'd0, 1'b1});
    add_vector(ModeCheck, '0, 24'd10, 24'd20, '0, IdxMax, 1'b1,
               {1'b1, 33'd0, 24'd10, 24'd20, 1'b1});
    add_vector(ModeStart, '0, '0, '0, '0, '0, 1'b1, {1'b1, 33'd0, 48'd0, 1'b0});
    add_vector(ModeNext, '0, '0, '0, '0, '0, 1'b0, '0);
    add_vector(ModeNext, '0, '0, '0, '0, '0, 1'b0, '0);
    add_vector(ModeStart, 11'd1024, '0, '0, '0, '0, 1'b1,
               {1'b1, 11'd1024, 22'd0, 48'd0, 1'b0});
    add_vector(ModeNext, '0, '0, '0, '0, '0, 1'b0, '0);
    add_vector(ModeNext, '0, '0, '0, '0, '0, 1'b0, '0);
    add_vector(ModeCheck, '0, IdxMax, IdxMax, '0, '0, 1'b0, '0);
    add_vector(ModeCheck, '0, '0, 24'd5, 24'd10, IdxMax, 1'b1, {1'b0, 33'd0, 48'd0, 1'b1});
    add_vector(ModeNext, '0, '0, '0, '0, '0, 1'b1, {1'b0, 33'd0, 48'd0, 1'b1});
    add_vector(ModeCheck, '0, '0, IdxMax, '0, IdxMax, 1'b1,
               {1'b1, 33'd0, 24'd0, IdxMax, 1'b1});
    add_vector(ModeStart, 11'd1023, '0, '0, '0, '0, 1'b1,
               {1'b1, 11'd1023, 22'd0, 48'd0, 1'b0});
    add_vector(ModeCheck, '0, 24'd2, IdxMax, 24'd3, IdxMax - 1'b1, 1'b1,
               {1'b1, 33'd0, 24'd3, IdxMax - 1'b1, 1'b1});
    add_vector(ModeStart, 11'd2, '0, '0, '0, '0, 1'b1, {1'b1, 11'd2, 22'd0, 48'd0, 1'b0});
    repeat (5) add_vector(ModeNext, '0, '0, '0, '0, '0, 1'b0, '0);
    add_vector(ModeCheck, '0, 24'd7, 24'd7, 24'd7, 24'd7, 1'b0, '0);
    add_vector(ModeStart, 11'd1, '0, '0, '0, '0, 1'b1, {1'b1, 11'd1, 22'd0, 48'd0, 1'b0});
    repeat (2) add_vector(ModeNext, '0, '0, '0, '0, '0, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i].req, directed[i].typed, directed[i].want);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      if (ph == NumPhases - 2) begin
        thr_plan[ph] = ThrW'($urandom_range(0, 65536));
        pop_plan[ph] = PopW'($urandom_range(0, MaxBits));
      end else if (ph == NumPhases - 1) begin
        thr_plan[ph] = ThrW'($urandom_range(40000, 65536));
        pop_plan[ph] = PopW'($urandom_range(0, 64));
      end
      write_registers(thr_plan[ph], pop_plan[ph]);
      counted = 0;
      while (counted < ItemsPerPhase) begin
        req = draw_request();
        send_item(req, 1'b0, '0);
        if (req.mode != ModeNop) counted++;
      end
    end
    wait_drained();

    // Anything still outstanding never came back
    mismatch_count += pending_results.size();
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
src/psos_pkg.sv
src/popcount_search_order_sequencer.sv
verif/popcount_search_order_sequencer_tb.sv
